### design/pec_pkg.sv
// ----------------------------------------------------------------------------
// pec_pkg
// Shared types, constants and the divide-by-five helper of the proof code
// letter encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pec_pkg;

  // Proof code width in use; bits above it are ignored.
  localparam int CodeWidth  = 32;
  // Longest spelling at the widest code.
  localparam int MaxLetters = 13;
  localparam int CntW       = $clog2(MaxLetters + 1);
  localparam int IdxW       = $clog2(MaxLetters);
  // Entries in the queue between front and back (power of two).
  localparam int QDepth     = 2;
  localparam int PtrW       = $clog2(QDepth);

  localparam int LetterW = 7;
  localparam int OffW    = 5;

  typedef logic [CodeWidth-1:0] code_t;
  typedef logic [CntW-1:0]      cnt_t;
  typedef logic [IdxW-1:0]      idx_t;
  typedef logic [OffW-1:0]      off_t;
  typedef logic [LetterW-1:0]   letter_t;

  // Letter offsets from 'A'
  localparam letter_t LetterA = 7'd65;
  localparam off_t    OffU    = 5'd20;
  localparam off_t    OffZ    = 5'd25;

  // Reciprocal of five, scaled by 2^34; exact for any 32-bit dividend.
  localparam logic [31:0] Recip5 = 32'hCCCC_CCCD;

  // One spelled code: letter offsets, least significant letter at index 0.
  typedef struct packed {
    off_t [MaxLetters-1:0] off;
    cnt_t                  n;
    logic                  err;
  } entry_t;

  // Quotient of a 32-bit value by five.
  function automatic logic [31:0] div5(input logic [31:0] x);
    logic [63:0] prod;
    prod = 64'(x) * 64'(Recip5);
    return {2'b00, prod[63:34]};
  endfunction

endpackage

`default_nettype wire

### design/pec_front.sv
// ----------------------------------------------------------------------------
// pec_front
// Accepts proof codes, classifies them and splits a normal code into its
// letter digits, one digit per cycle through a shared divide-by-five unit.
// ----------------------------------------------------------------------------
`default_nettype none

module pec_front (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire  [31:0]           code_i,
  input  wire                   code_valid_i,
  output logic                  code_ready_o,
  output logic                  push_valid_o,
  input  wire                   push_ready_i,
  output pec_pkg::entry_t       push_entry_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIRST,
    S_DIGIT,
    S_PUSH
  } state_e;

  state_e          state_q, state_d;
  pec_pkg::code_t  val_q, val_d;
  pec_pkg::entry_t ent_q, ent_d;

  pec_pkg::code_t  code_m;
  pec_pkg::code_t  div_op;
  logic [31:0]     quo32;
  pec_pkg::code_t  quo;
  logic [2:0]      rem;
  logic            accept;

  // Mask the code to the working width
  assign code_m = pec_pkg::code_t'(code_i);
  assign accept = code_valid_i && (state_q == S_IDLE);

  // Shared divide-by-five: first step takes (c-1)/4, later steps take q-1
  assign div_op = (state_q == S_FIRST) ? (val_q >> 2) : (val_q - pec_pkg::code_t'(1));
  assign quo32  = pec_pkg::div5(32'(div_op));
  assign quo    = pec_pkg::code_t'(quo32);
  assign rem    = 3'(32'(div_op) - (quo32 << 2) - quo32);

  // Next state and digit capture
  always_comb begin
    state_d = state_q;
    val_d   = val_q;
    ent_d   = ent_q;
    case (state_q)
      S_IDLE: begin
        if (code_valid_i) begin
          ent_d.n   = pec_pkg::cnt_t'(1);
          ent_d.err = 1'b0;
          val_d     = code_m - pec_pkg::code_t'(1);
          if (code_m == '1) begin
            ent_d.err = 1'b1;
            state_d   = S_PUSH;
          end else if (code_m == '0) begin
            ent_d.off[0] = pec_pkg::OffZ;
            state_d      = S_PUSH;
          end else begin
            ent_d.n = '0;
            state_d = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        // Base-20 digit: four times the base-5 remainder plus the low two bits
        ent_d.off[0] = {rem, val_q[1:0]};
        ent_d.n      = pec_pkg::cnt_t'(1);
        val_d        = quo;
        state_d      = (quo == '0) ? S_PUSH : S_DIGIT;
      end
      S_DIGIT: begin
        ent_d.off[ent_q.n[pec_pkg::IdxW-1:0]] = pec_pkg::OffU + pec_pkg::off_t'(rem);
        ent_d.n = pec_pkg::cnt_t'(ent_q.n + pec_pkg::cnt_t'(1));
        val_d   = quo;
        if (quo == '0 || ent_d.n == pec_pkg::cnt_t'(pec_pkg::MaxLetters)) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (push_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state, working value and the entry being built
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      val_q   <= '0;
      ent_q   <= '0;
    end else begin
      state_q <= state_d;
      val_q   <= val_d;
      ent_q   <= ent_d;
    end
  end

  assign code_ready_o = (state_q == S_IDLE);
  assign push_valid_o = (state_q == S_PUSH);
  assign push_entry_o = ent_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIGIT) |-> (ent_q.n < pec_pkg::cnt_t'(pec_pkg::MaxLetters)))
    else $error("front digit count overran the letter limit");
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("front stayed idle after taking a code");
  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_o |-> (ent_q.n != '0))
    else $error("front pushed an entry with no letters");
`endif

endmodule

`default_nettype wire

### design/pec_queue.sv
// ----------------------------------------------------------------------------
// pec_queue
// Short first-in first-out queue of spelled codes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module pec_queue (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              wr_valid_i,
  output logic             wr_ready_o,
  input  pec_pkg::entry_t  wr_entry_i,
  output logic             rd_valid_o,
  input  wire              rd_pop_i,
  output pec_pkg::entry_t  rd_entry_o
);

  pec_pkg::entry_t           mem_q [pec_pkg::QDepth];
  logic [pec_pkg::PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [pec_pkg::PtrW:0]    cnt_q;
  logic                      do_wr, do_rd;

  assign wr_ready_o = (cnt_q != (pec_pkg::PtrW+1)'(pec_pkg::QDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_pop_i && rd_valid_o;
  assign rd_entry_o = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (pec_pkg::PtrW+1)'(pec_pkg::QDepth))
    else $error("queue fill count beyond depth");
`endif

endmodule

`default_nettype wire

### design/pec_back.sv
// ----------------------------------------------------------------------------
// pec_back
// Emits the letters of the queue head, most significant first, one word per
// cycle while the receiver takes each word, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pec_back (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       head_valid_i,
  input  pec_pkg::entry_t           head_entry_i,
  output logic                      head_pop_o,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output pec_pkg::letter_t          out_letter_o,
  output logic                      out_last_o,
  output logic                      out_err_o
);

  logic              valid_q;
  pec_pkg::letter_t  letter_q;
  logic              last_q, err_q;
  logic              active_q;
  pec_pkg::idx_t     idx_q;

  logic              load;
  pec_pkg::idx_t     cur_idx;
  pec_pkg::letter_t  cur_letter;

  // Output register is free when empty or being taken
  assign load    = !valid_q || out_ready_i;
  assign cur_idx = active_q ? idx_q
                 : pec_pkg::idx_t'(head_entry_i.n - pec_pkg::cnt_t'(1));
  assign cur_letter = head_entry_i.err ? '0
                    : pec_pkg::LetterA + pec_pkg::letter_t'(head_entry_i.off[cur_idx]);
  assign head_pop_o = load && head_valid_i && (cur_idx == '0);

  // Step through the head entry and fill the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      letter_q <= '0;
      last_q   <= 1'b0;
      err_q    <= 1'b0;
      active_q <= 1'b0;
      idx_q    <= '0;
    end else if (load) begin
      valid_q <= head_valid_i;
      if (head_valid_i) begin
        letter_q <= cur_letter;
        last_q   <= (cur_idx == '0);
        err_q    <= head_entry_i.err;
        active_q <= (cur_idx != '0);
        idx_q    <= cur_idx - 1'b1;
      end
    end
  end

  assign out_valid_o  = valid_q;
  assign out_letter_o = letter_q;
  assign out_last_o   = last_q;
  assign out_err_o    = err_q;

`ifndef NO_ASSERTIONS
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && err_q) |-> (last_q && letter_q == '0))
    else $error("error word must be a single last word with letter zero");
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop_o |=> (valid_q && last_q && !active_q))
    else $error("queue entry retired without emitting its last letter");
`endif

endmodule

`default_nettype wire

### design/proof_code_to_letter_encoder.sv
// ----------------------------------------------------------------------------
// proof_code_to_letter_encoder
// Spells one proof code per input word as letters A..Z, most significant
// letter first, one output word per letter.
// ----------------------------------------------------------------------------
// A code passes the front end in order: it is taken and classified, each
// letter is split off in turn by the shared divide-by-five unit, and the
// result is handed to the two-entry queue (zero and the invalid code skip
// the divider). The back end sends one letter per cycle while the receiver
// takes each word, and a spelling has at most 13 letters. The queue lets the
// next code be split while the previous one is still being sent. The
// all-ones code gives one word with tuser set, letter 0 and tlast.
// ----------------------------------------------------------------------------
`default_nettype none

module proof_code_to_letter_encoder (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // [31:0] code
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] letter, [7] zero
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // [0] error
);

  logic                 push_valid, push_ready;
  pec_pkg::entry_t      push_entry;
  logic                 head_valid, head_pop;
  pec_pkg::entry_t      head_entry;
  pec_pkg::letter_t     letter;

  // Classify and split codes
  pec_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .code_i       (s_axis_tdata),
    .code_valid_i (s_axis_tvalid),
    .code_ready_o (s_axis_tready),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  // Buffer spelled codes
  pec_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_entry_i (push_entry),
    .rd_valid_o (head_valid),
    .rd_pop_i   (head_pop),
    .rd_entry_o (head_entry)
  );

  // Send letters
  pec_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_entry_i (head_entry),
    .head_pop_o   (head_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_letter_o (letter),
    .out_last_o   (m_axis_tlast),
    .out_err_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, letter};

endmodule

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for proof_code_to_letter_encoder. Proof codes go in on
// the slave stream and a scoreboard predicts the letter words of each code:
// Z for zero, a single error word for the all-ones code, and otherwise the
// mixed-radix spelling with base-5 letters U..Y ahead of a final A..T letter.
// Each output word is checked field by field against the oldest prediction.
// Both sides insert random gaps, and some phases run with no gaps at all.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 5000;
  localparam int DrainCycles = 40;

  // One predicted letter word
  typedef struct packed {
    pec_pkg::letter_t letter;
    logic             last;
    logic             err;
  } spelled_t;

  class letter_scoreboard;
    spelled_t pending_letters[$];
    int       errors;
    int       codes_seen;
    int       letters_checked;
    int       invalid_seen;
    int       longest_run;

    function new();
      errors = 0;
      codes_seen = 0;
      letters_checked = 0;
      invalid_seen = 0;
      longest_run = 0;
    endfunction

    function int pending_count();
      return pending_letters.size();
    endfunction

    // Spell one accepted code and queue its letters, most significant first
    function void note_code(pec_pkg::code_t code);
      logic [31:0]      val;
      logic [31:0]      quot;
      pec_pkg::letter_t rev_letters[$];
      spelled_t         word;
      codes_seen++;
      if (code == '1) begin
        invalid_seen++;
        word = '{letter: '0, last: 1'b1, err: 1'b1};
        pending_letters = {pending_letters, word};
        if (longest_run < 1) longest_run = 1;
      end else if (code == '0) begin
        word = '{letter: pec_pkg::letter_t'(pec_pkg::LetterA + pec_pkg::OffZ),
                 last: 1'b1, err: 1'b0};
        pending_letters = {pending_letters, word};
        if (longest_run < 1) longest_run = 1;
      end else begin
        val = code - 32'd1;
        rev_letters = {rev_letters, pec_pkg::letter_t'(pec_pkg::LetterA + val % 20)};
        quot = val / 20;
        while (quot != 0) begin
          rev_letters = {rev_letters,
                         pec_pkg::letter_t'(pec_pkg::LetterA + pec_pkg::OffU
                                            + (quot - 1) % 5)};
          quot = (quot - 1) / 5;
        end
        for (int k = rev_letters.size() - 1; k >= 0; k--) begin
          word = '{letter: rev_letters[k], last: (k == 0), err: 1'b0};
          pending_letters = {pending_letters, word};
        end
        if (longest_run < rev_letters.size()) longest_run = rev_letters.size();
      end
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
      errors++;
    endtask

    // Compare one output word against the oldest prediction
    task check_letter(logic [7:0] data, logic tlast, logic tuser);
      spelled_t want;
      letters_checked++;
      if (pending_letters.size() == 0) begin
        report_mismatch("unexpected word, letter", data[6:0], 0);
      end else begin
        want = pending_letters.pop_front();
        if (data[6:0] !== want.letter) report_mismatch("letter", data[6:0], want.letter);
        if (data[7] !== 1'b0) report_mismatch("tdata pad bit", data[7], 0);
        if (tlast !== want.last) report_mismatch("tlast", tlast, want.last);
        if (tuser !== want.err) report_mismatch("tuser error", tuser, want.err);
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;    // [31:0] code
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [6:0] letter, [7] zero
  logic        m_axis_tlast;
  logic        m_axis_tuser;         // [0] error

  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int idle_cycles = 0;

  letter_scoreboard sb = new();

  proof_code_to_letter_encoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Gap length: a gap in pct percent of draws, mostly short, now and then long
  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
    return $urandom_range(1, 3);
  endfunction

  // Mix of small codes, codes of every length, and codes near all ones
  function automatic pec_pkg::code_t pick_code();
    case ($urandom_range(0, 9))
      0:       return pec_pkg::code_t'($urandom_range(0, 30));
      1, 2:    return pec_pkg::code_t'($urandom_range(0, 3000));
      3:       return '1 - pec_pkg::code_t'($urandom_range(0, 2));
      4, 5:    return pec_pkg::code_t'($urandom >> $urandom_range(0, 31));
      default: return pec_pkg::code_t'($urandom);
    endcase
  endfunction

  // Present one code word and hold it until accepted
  task automatic send_code(pec_pkg::code_t code, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_code(pick_code(), pick_gap(tx_gap_pct));
  endtask

  // Receiver: random stalls of random length
  initial begin
    int stall_left;
    int n;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        n = pick_gap(rx_stall_pct);
        if (n > 0) begin
          m_axis_tready <= 1'b0;
          stall_left = n - 1;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // Track accepted words on both sides
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_code(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_letter(m_axis_tdata, m_axis_tlast,
                                                          m_axis_tuser);
    end
  end

  // Abort when no word moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("timeout: no word accepted for %0d cycles", IdleLimit);
        $display("testbench: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    pec_pkg::code_t directed_codes[$];
    directed_codes = '{32'd0, 32'd1, 32'd2, 32'd19, 32'd20, 32'd21, 32'd22, 32'd120,
                       32'd121, 32'd620, 32'd621, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                       32'hFFFF_FFFD, 32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA,
                       32'h5555_5555, 32'hFFFF_FFFF, 32'd0, 32'd3125};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes, zero, invalid code, length boundaries; no idling
    foreach (directed_codes[i]) send_code(directed_codes[i], 0);

    // Random with moderate gaps on both sides
    tx_gap_pct = 30;
    rx_stall_pct = 30;
    send_random(80);

    // Hold the sender until the encoder has fully drained
    s_axis_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(negedge clk_i);

    // Stretch with no idling at all
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    send_random(60);

    // Heavy receiver stalls, light sender gaps
    tx_gap_pct = 10;
    rx_stall_pct = 60;
    send_random(50);

    // Heavy sender gaps, free-running receiver
    tx_gap_pct = 70;
    rx_stall_pct = 0;
    send_random(50);

    s_axis_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.pending_count() != 0) sb.report_mismatch("words never seen", 0,
                                                    sb.pending_count());
    $display("covered %0d codes (%0d invalid), %0d letter words checked,",
             sb.codes_seen, sb.invalid_seen, sb.letters_checked);
    $display("longest spelling %0d letters, gaps and stalls on both sides",
             sb.longest_run);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
design/pec_pkg.sv
design/pec_front.sv
design/pec_queue.sv
design/pec_back.sv
design/proof_code_to_letter_encoder.sv
verif/testbench.sv
